>>> rtl/eod_pkg.sv
// Shared types and constants of the elevator order dispatcher.
package eod_pkg;

	localparam int FLOORS_DEF = 4;
	localparam int FLOOR_W    = 2;
	localparam int BTN_W      = 2;
	localparam int DIR_W      = 2;

	typedef enum logic [1:0] {
		OP_PRESS = 2'd0,
		OP_SERVE = 2'd1,
		OP_CLEAR = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	localparam logic [BTN_W-1:0] BTN_UP   = 2'd0;
	localparam logic [BTN_W-1:0] BTN_DOWN = 2'd1;
	localparam logic [BTN_W-1:0] BTN_CAB  = 2'd2;

	localparam logic signed [DIR_W-1:0] DIR_DOWN = -2'sd1;
	localparam logic signed [DIR_W-1:0] DIR_STOP = 2'sd0;
	localparam logic signed [DIR_W-1:0] DIR_UP   = 2'sd1;

endpackage

>>> rtl/elevator_order_dispatcher_core.sv
// Top level of the elevator order dispatcher: order state, update and result logic.

// The dispatcher keeps the pending orders of one elevator car: a mark per
// floor for the hall up, hall down and cab buttons, plus an ordered cab
// queue without duplicates. Every accepted item (press, serve, clear or
// query) updates that state and yields exactly one result item, computed
// on the updated state: the direction to drive from the given floor, the
// stop decision for that floor and the current travel direction, and a
// flag that tells whether nothing is pending. One item can be taken in every
// clock cycle while item_stall is low. The clock edge that accepts an item
// loads it into the input register; it moves on into the result register
// once that is free or being taken, and is offered on the result port.
// The whole update and decision for an item is a single pass of small logic
// over at most four floors, because the two-bit floor field can only
// reach floors zero to three even when FLOORS is set larger. The result
// register releases its item on a clean handshake. While the result side
// stalls with a full result register, the input register keeps its item,
// and the input side stalls only when the input register is also full.
// After reset all marks are clear and the cab queue is empty.
module elevator_order_dispatcher_core #(
	parameter int FLOORS = eod_pkg::FLOORS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic [1:0]                             op,
	input  logic [eod_pkg::FLOOR_W-1:0]            floor,
	input  logic [eod_pkg::BTN_W-1:0]              button,
	input  logic signed [eod_pkg::DIR_W-1:0]       travel_dir,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic signed [eod_pkg::DIR_W-1:0]       next_dir,
	output logic                                   should_stop,
	output logic                                   all_done
);

	// Floors that an item can actually name.
	localparam int NF    = (FLOORS < (1 << eod_pkg::FLOOR_W)) ? FLOORS
		: (1 << eod_pkg::FLOOR_W);
	localparam int LEN_W = $clog2(NF + 1);
	localparam int CNT_W = $clog2(2 * NF + 1);
	localparam logic [eod_pkg::FLOOR_W:0] NF_V = (eod_pkg::FLOOR_W + 1)'(NF);

	// Input register.
	logic                                 valid_s1;
	eod_pkg::op_t                         op_s1;
	logic [eod_pkg::FLOOR_W-1:0]          floor_s1;
	logic [eod_pkg::BTN_W-1:0]            button_s1;
	logic signed [eod_pkg::DIR_W-1:0]     dir_s1;

	// Order state.
	logic [2:0]                  marks_q [NF];
	logic [eod_pkg::FLOOR_W-1:0] queue_q [NF];
	logic [LEN_W-1:0]            len_q;

	logic [2:0]                  marks_d [NF];
	logic [eod_pkg::FLOOR_W-1:0] queue_d [NF];
	logic [LEN_W-1:0]            len_d;

	// Result register.
	logic                             out_valid_q;
	logic signed [eod_pkg::DIR_W-1:0] next_dir_q;
	logic                             stop_q;
	logic                             done_q;

	logic                             advance;
	logic                             load_s1;
	logic                             floor_ok;
	logic [NF-1:0]                    hit;
	logic                             seen;
	logic                             queued_d;
	logic                             up_here;
	logic                             down_here;
	logic                             any_up;
	logic                             any_down;
	logic                             any_mark;
	logic                             no_ahead;
	logic [CNT_W-1:0]                 above;
	logic [CNT_W-1:0]                 below;
	logic signed [eod_pkg::DIR_W-1:0] dir_calc;
	logic                             stop_calc;
	logic                             done_calc;

	// The stage moves whenever the result register is free or being taken.
	// The input register takes a new item when it is empty or moving on.
	assign advance    = !out_valid_q || !result_stall;
	assign load_s1    = !valid_s1 || advance;
	assign item_stall = !load_s1;
	assign floor_ok   = ({1'b0, floor_s1} < NF_V);

	// Cab queue entries that hold the item's floor, before the update.
	always_comb begin
		for (int i = 0; i < NF; i++) begin
			hit[i] = (LEN_W'(i) < len_q) && (queue_q[i] == floor_s1);
		end
	end

	// State update for the item in the input register.
	always_comb begin
		marks_d = marks_q;
		queue_d = queue_q;
		len_d   = len_q;
		seen    = 1'b0;
		unique case (op_s1)
			eod_pkg::OP_PRESS: begin
				if (floor_ok && button_s1 != 2'd3) begin
					for (int f = 0; f < NF; f++) begin
						if (eod_pkg::FLOOR_W'(f) == floor_s1) begin
							marks_d[f][button_s1] = 1'b1;
						end
					end
					if (button_s1 == eod_pkg::BTN_CAB && hit == '0
						&& len_q < LEN_W'(NF)) begin
						for (int i = 0; i < NF; i++) begin
							if (LEN_W'(i) == len_q) begin
								queue_d[i] = floor_s1;
							end
						end
						len_d = len_q + LEN_W'(1);
					end
				end
			end
			eod_pkg::OP_SERVE: begin
				if (floor_ok) begin
					for (int f = 0; f < NF; f++) begin
						if (eod_pkg::FLOOR_W'(f) == floor_s1) begin
							marks_d[f] = 3'b000;
						end
					end
					// Entries from the served one onward move one place forward.
					for (int j = 0; j < NF - 1; j++) begin
						seen = seen | hit[j];
						if (seen) begin
							queue_d[j] = queue_q[j + 1];
						end
					end
					if (hit != '0) begin
						len_d = len_q - LEN_W'(1);
					end
				end
			end
			eod_pkg::OP_CLEAR: begin
				for (int f = 0; f < NF; f++) begin
					marks_d[f] = 3'b000;
				end
				len_d = '0;
			end
			eod_pkg::OP_QUERY: begin
			end
			default: begin
			end
		endcase
	end

	// Decisions on the updated state.
	always_comb begin
		queued_d  = 1'b0;
		up_here   = 1'b0;
		down_here = 1'b0;
		any_up    = 1'b0;
		any_down  = 1'b0;
		any_mark  = 1'b0;
		above     = '0;
		below     = '0;
		for (int i = 0; i < NF; i++) begin
			if (LEN_W'(i) < len_d && queue_d[i] == floor_s1) begin
				queued_d = 1'b1;
			end
		end
		for (int f = 0; f < NF; f++) begin
			any_up   = any_up | marks_d[f][eod_pkg::BTN_UP];
			any_down = any_down | marks_d[f][eod_pkg::BTN_DOWN];
			any_mark = any_mark | (marks_d[f] != 3'b000);
			if (eod_pkg::FLOOR_W'(f) == floor_s1) begin
				up_here   = marks_d[f][eod_pkg::BTN_UP];
				down_here = marks_d[f][eod_pkg::BTN_DOWN];
			end
			if (eod_pkg::FLOOR_W'(f) < floor_s1) begin
				below = below + CNT_W'(marks_d[f][eod_pkg::BTN_UP])
					+ CNT_W'(marks_d[f][eod_pkg::BTN_DOWN]);
			end else if (eod_pkg::FLOOR_W'(f) > floor_s1) begin
				above = above + CNT_W'(marks_d[f][eod_pkg::BTN_UP])
					+ CNT_W'(marks_d[f][eod_pkg::BTN_DOWN]);
			end
		end

		// The queue head wins; otherwise the side with more hall calls, up on a tie.
		priority if (len_d != '0 && queue_d[0] < floor_s1) begin
			dir_calc = eod_pkg::DIR_DOWN;
		end else if (len_d != '0 && queue_d[0] > floor_s1) begin
			dir_calc = eod_pkg::DIR_UP;
		end else if (len_d != '0) begin
			dir_calc = eod_pkg::DIR_STOP;
		end else if (above >= below && above != '0) begin
			dir_calc = eod_pkg::DIR_UP;
		end else if (below > above) begin
			dir_calc = eod_pkg::DIR_DOWN;
		end else begin
			dir_calc = eod_pkg::DIR_STOP;
		end

		// A stopped car, or the unused direction code, has no call ahead.
		priority if (dir_s1 == eod_pkg::DIR_UP) begin
			no_ahead = !any_up;
		end else if (dir_s1 == eod_pkg::DIR_DOWN) begin
			no_ahead = !any_down;
		end else begin
			no_ahead = 1'b1;
		end

		// Marks beyond the reachable floors never exist, so up_here and
		// down_here stay clear for such a floor.
		stop_calc = queued_d
			|| (dir_s1 == eod_pkg::DIR_DOWN && down_here)
			|| (dir_s1 == eod_pkg::DIR_UP && up_here)
			|| (no_ahead && (up_here || down_here));

		done_calc = (len_d == '0) && !any_mark;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			len_q       <= '0;
			for (int f = 0; f < NF; f++) begin
				marks_q[f] <= 3'b000;
			end
		end else begin
			if (load_s1) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					len_q   <= len_d;
					marks_q <= marks_d;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (load_s1) begin
			op_s1     <= eod_pkg::op_t'(op);
			floor_s1  <= floor;
			button_s1 <= button;
			dir_s1    <= travel_dir;
		end
		if (advance && valid_s1) begin
			queue_q    <= queue_d;
			next_dir_q <= dir_calc;
			stop_q     <= stop_calc;
			done_q     <= done_calc;
		end
	end

	assign result_valid = out_valid_q;
	assign next_dir     = next_dir_q;
	assign should_stop  = stop_q;
	assign all_done     = done_q;

endmodule
